// ===== src/bwdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bwdt_pkg;

    // Depth of each basis window and the widths that follow from it.
    localparam int WINDOW_DEPTH = 256;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int COUNT_W      = $clog2(WINDOW_DEPTH) + 1;

    // Fixed field widths.
    localparam int PRICE_W  = 32;
    localparam int DELTA_W  = 32;
    localparam int WSIZE_W  = 9;
    localparam int CFG_W    = 32;
    localparam int BASIS_W  = PRICE_W + 1;
    localparam int SUM_W    = BASIS_W + COUNT_W - 1;
    localparam int PROD_W   = SUM_W + 1;
    localparam int LIM_W    = DELTA_W + COUNT_W;
    localparam int ENTRY_W  = 2 * BASIS_W;

    localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RESET = WSIZE_W'(16);

    typedef enum logic [1:0] {
        ACT_NONE       = 2'd0,
        ACT_BUY_FIRST  = 2'd1,
        ACT_SELL_FIRST = 2'd2
    } action_t;

    typedef enum logic {
        REG_WINDOW_SIZE = 1'b0,
        REG_OPEN_DELTA  = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/basis_window_deviation_trigger.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Basis window deviation trigger. Each input word carries the best bid and
// ask of two instruments; the block forms the long basis (second_bid -
// first_ask) and the short basis (second_ask - first_bid) and keeps the last
// window_size values of each in a window RAM with running sums. Once the
// windows are full, a basis triggers when |basis*count - sum| >=
// open_delta*count, the exact integer form of a deviation from the window
// mean of at least open_delta ticks; the long test wins over the short test.
// Every input word yields exactly one output word: action 1 reports
// first_ask/second_bid, action 2 reports first_bid/second_ask, and action 0
// reports both prices as zero. The block takes one word per clock cycle while
// the output is not stalled, and a result passes through the input register
// (which also captures the window RAM read), the compare register (which
// takes the products, the limit and the sums) and the output register. The
// window RAM is read one entry per word and written one entry per word, so
// the sustained rate is one word per cycle for any window size while the
// output is not stalled; a word that reads the slot its predecessor is writing
// (window size one) is served by a forwarding register. Writing window_size
// (register 0) empties both windows at once; window sizes of zero act as one
// and sizes above the window depth are held at the depth. Configuration must
// be written only while the block is empty; the block does not enforce this.
module basis_window_deviation_trigger
    import bwdt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [PRICE_W-1:0] first_bid,
    input  wire logic [PRICE_W-1:0] first_ask,
    input  wire logic [PRICE_W-1:0] second_bid,
    input  wire logic [PRICE_W-1:0] second_ask,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              action,
    output logic [PRICE_W-1:0]      first_leg_price,
    output logic [PRICE_W-1:0]      second_leg_price
);

    // Configuration registers.
    logic [WSIZE_W-1:0] window_size_reg;
    logic [DELTA_W-1:0] open_delta_reg;

    // Window bookkeeping, advanced at input acceptance.
    logic [COUNT_W-1:0] fill_count_reg;
    logic [ADDR_W-1:0]  slot_ptr_reg;

    // Running sums, advanced as a word leaves the input stage.
    logic signed [SUM_W-1:0] long_sum_reg;
    logic signed [SUM_W-1:0] short_sum_reg;

    // Input stage.
    logic               s0_valid_reg;
    logic [PRICE_W-1:0] s0_first_bid_reg;
    logic [PRICE_W-1:0] s0_first_ask_reg;
    logic [PRICE_W-1:0] s0_second_bid_reg;
    logic [PRICE_W-1:0] s0_second_ask_reg;
    logic [ADDR_W-1:0]  s0_ptr_reg;
    logic               s0_full_reg;
    logic [COUNT_W-1:0] s0_count_reg;
    logic               fwd_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;

    // Compare stage.
    logic                     s1_valid_reg;
    logic [PRICE_W-1:0]       s1_first_bid_reg;
    logic [PRICE_W-1:0]       s1_first_ask_reg;
    logic [PRICE_W-1:0]       s1_second_bid_reg;
    logic [PRICE_W-1:0]       s1_second_ask_reg;
    logic                     s1_full_reg;
    logic signed [PROD_W-1:0] s1_long_prod_reg;
    logic signed [PROD_W-1:0] s1_short_prod_reg;
    logic signed [SUM_W-1:0]  s1_long_sum_reg;
    logic signed [SUM_W-1:0]  s1_short_sum_reg;
    logic [LIM_W-1:0]         s1_lim_reg;

    // Output register.
    logic               out_valid_reg;
    action_t            action_reg;
    logic [PRICE_W-1:0] first_leg_reg;
    logic [PRICE_W-1:0] second_leg_reg;

    // Handshake and stage movement.
    logic in_accept;
    logic out_ready;
    logic s1_ready;
    logic s0_ready;
    logic s0_adv;
    logic s1_adv;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign s0_ready  = !s0_valid_reg || s1_ready;
    assign s0_adv    = s0_valid_reg && s1_ready;
    assign s1_adv    = s1_valid_reg && out_ready;
    assign in_stall  = !s0_ready;
    assign in_accept = in_valid && s0_ready;

    // Effective window length: zero acts as one, large values saturate.
    logic [COUNT_W-1:0] win_n;

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_n = COUNT_W'(1);
        end
        else if (int'(window_size_reg) > WINDOW_DEPTH)
        begin
            win_n = COUNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            win_n = COUNT_W'(window_size_reg);
        end
    end

    // Slot selection at acceptance.
    logic [ADDR_W-1:0]  p_use;
    logic [COUNT_W-1:0] p_plus;
    logic [ADDR_W-1:0]  slot_ptr_next;
    logic               full_now;
    logic [COUNT_W-1:0] fill_count_next;

    assign p_use         = (COUNT_W'(slot_ptr_reg) >= win_n) ? '0 : slot_ptr_reg;
    assign p_plus        = COUNT_W'(p_use) + COUNT_W'(1);
    assign slot_ptr_next = (p_plus >= win_n) ? '0 : p_plus[ADDR_W-1:0];
    assign full_now      = fill_count_reg >= win_n;
    assign fill_count_next = full_now ? fill_count_reg
                                      : fill_count_reg + COUNT_W'(1);

    // Input stage arithmetic: bases, products, limit and the sum update.
    logic signed [BASIS_W-1:0] basis_long;
    logic signed [BASIS_W-1:0] basis_short;
    logic signed [COUNT_W:0]   count_s;
    logic signed [PROD_W-1:0]  long_prod;
    logic signed [PROD_W-1:0]  short_prod;
    logic [LIM_W-1:0]          lim;
    logic [ENTRY_W-1:0]        ram_rdata;
    logic [ENTRY_W-1:0]        old_entry;
    logic signed [SUM_W-1:0]   long_drop;
    logic signed [SUM_W-1:0]   short_drop;
    logic signed [SUM_W-1:0]   long_sum_next;
    logic signed [SUM_W-1:0]   short_sum_next;
    logic                      fwd_next;

    assign basis_long  = $signed({1'b0, s0_second_bid_reg}) - $signed({1'b0, s0_first_ask_reg});
    assign basis_short = $signed({1'b0, s0_second_ask_reg}) - $signed({1'b0, s0_first_bid_reg});
    assign count_s     = $signed({1'b0, s0_count_reg});
    assign long_prod   = PROD_W'(basis_long) * PROD_W'(count_s);
    assign short_prod  = PROD_W'(basis_short) * PROD_W'(count_s);
    assign lim         = LIM_W'(open_delta_reg) * LIM_W'(s0_count_reg);

    // The oldest entry only matters once the window is full.
    assign old_entry  = fwd_reg ? fwd_data_reg : ram_rdata;
    assign long_drop  = s0_full_reg ? SUM_W'($signed(old_entry[ENTRY_W-1:BASIS_W])) : '0;
    assign short_drop = s0_full_reg ? SUM_W'($signed(old_entry[BASIS_W-1:0])) : '0;
    assign long_sum_next  = long_sum_reg - long_drop + SUM_W'(basis_long);
    assign short_sum_next = short_sum_reg - short_drop + SUM_W'(basis_short);

    // A new word reading the slot that the current word writes at this very
    // edge takes the written value instead of the stale RAM contents.
    assign fwd_next = s0_adv && (s0_ptr_reg == p_use);

    bwdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window_ram (
        .clk   (clk),
        .we    (s0_adv),
        .waddr (s0_ptr_reg),
        .wdata ({basis_long, basis_short}),
        .re    (in_accept),
        .raddr (p_use),
        .rdata (ram_rdata)
    );

    // Compare stage.
    logic long_hit;
    logic short_hit;

    bwdt_dev_check u_long_check (
        .prod (s1_long_prod_reg),
        .sum  (s1_long_sum_reg),
        .lim  (s1_lim_reg),
        .hit  (long_hit)
    );

    bwdt_dev_check u_short_check (
        .prod (s1_short_prod_reg),
        .sum  (s1_short_sum_reg),
        .lim  (s1_lim_reg),
        .hit  (short_hit)
    );

    action_t            action_next;
    logic [PRICE_W-1:0] first_leg_next;
    logic [PRICE_W-1:0] second_leg_next;

    always_comb
    begin
        if (s1_full_reg && long_hit)
        begin
            action_next     = ACT_BUY_FIRST;
            first_leg_next  = s1_first_ask_reg;
            second_leg_next = s1_second_bid_reg;
        end
        else if (s1_full_reg && short_hit)
        begin
            action_next     = ACT_SELL_FIRST;
            first_leg_next  = s1_first_bid_reg;
            second_leg_next = s1_second_ask_reg;
        end
        else
        begin
            action_next     = ACT_NONE;
            first_leg_next  = '0;
            second_leg_next = '0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
            open_delta_reg  <= '0;
            fill_count_reg  <= '0;
            slot_ptr_reg    <= '0;
            long_sum_reg    <= '0;
            short_sum_reg   <= '0;
            s0_valid_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                fill_count_reg <= fill_count_next;
                slot_ptr_reg   <= slot_ptr_next;
                s0_valid_reg   <= 1'b1;
            end
            else if (s0_adv)
            begin
                s0_valid_reg <= 1'b0;
            end

            if (s0_adv)
            begin
                long_sum_reg  <= long_sum_next;
                short_sum_reg <= short_sum_next;
                s1_valid_reg  <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Configuration must arrive only while the block is empty, which is not
            // enforced here; its clearing of the windows overrides the word updates above.
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_WINDOW_SIZE:
                    begin
                        window_size_reg <= cfg_data[WSIZE_W-1:0];
                        fill_count_reg  <= '0;
                        slot_ptr_reg    <= '0;
                        long_sum_reg    <= '0;
                        short_sum_reg   <= '0;
                    end
                    REG_OPEN_DELTA:
                    begin
                        open_delta_reg <= cfg_data[DELTA_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s0_first_bid_reg  <= first_bid;
            s0_first_ask_reg  <= first_ask;
            s0_second_bid_reg <= second_bid;
            s0_second_ask_reg <= second_ask;
            s0_ptr_reg        <= p_use;
            s0_full_reg       <= full_now;
            s0_count_reg      <= fill_count_reg;
            fwd_reg           <= fwd_next;
            fwd_data_reg      <= {basis_long, basis_short};
        end

        if (s0_adv)
        begin
            s1_first_bid_reg  <= s0_first_bid_reg;
            s1_first_ask_reg  <= s0_first_ask_reg;
            s1_second_bid_reg <= s0_second_bid_reg;
            s1_second_ask_reg <= s0_second_ask_reg;
            s1_full_reg       <= s0_full_reg;
            s1_long_prod_reg  <= long_prod;
            s1_short_prod_reg <= short_prod;
            s1_long_sum_reg   <= long_sum_reg;
            s1_short_sum_reg  <= short_sum_reg;
            s1_lim_reg        <= lim;
        end

        if (s1_adv)
        begin
            action_reg     <= action_next;
            first_leg_reg  <= first_leg_next;
            second_leg_reg <= second_leg_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign action           = action_reg;
    assign first_leg_price  = first_leg_reg;
    assign second_leg_price = second_leg_reg;

    // The fill count never runs past the effective window length.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= win_n)
        else $error("fill count exceeds window length");

    // The write slot always lies inside the effective window.
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        COUNT_W'(slot_ptr_reg) < win_n)
        else $error("slot pointer outside window");

    // A word that reaches the compare stage before the window is full
    // leaves with no action.
    a_no_trigger_unfilled: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_full_reg) |=> (action_reg == ACT_NONE))
        else $error("trigger before window full");

    // A word with no action carries zero prices.
    a_none_zero_prices: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && action_reg == ACT_NONE)
            |-> (first_leg_reg == '0 && second_leg_reg == '0))
        else $error("nonzero prices without action");

endmodule

`default_nettype wire

// ===== src/bwdt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bwdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/bwdt_dev_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Decides |prod - sum| >= lim without forming the magnitude: the deviation
// is compared against both +lim and -lim.
module bwdt_dev_check
    import bwdt_pkg::*;
(
    input  wire logic signed [PROD_W-1:0] prod,
    input  wire logic signed [SUM_W-1:0]  sum,
    input  wire logic        [LIM_W-1:0]  lim,
    output logic                          hit
);

    logic signed [PROD_W-1:0] dev;
    logic signed [PROD_W-1:0] lim_pos;
    logic signed [PROD_W-1:0] lim_neg;

    assign dev     = prod - PROD_W'(sum);
    assign lim_pos = $signed(PROD_W'(lim));
    assign lim_neg = -lim_pos;
    assign hit     = (dev >= lim_pos) || (dev <= lim_neg);

endmodule

`default_nettype wire
